>>> rtl/touch_report_slot_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Touch report slot decoder assertion macros
// Concurrent checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_SLOT_DECODER_CORE_ASSERT_SVH
`define TOUCH_REPORT_SLOT_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TRSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TRSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TRSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/trsd_pkg.sv
// ----------------------------------------------------------------------------
// Touch report slot decoder package
// Shared constants, event codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package trsd_pkg;

  localparam int NUM_SLOTS  = 10;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 6;
  localparam int COORD_W    = 12;
  localparam int OUT_DATA_W = 32;

  localparam logic [CNT_W-1:0]  CNT_MAX     = 6'd63;
  localparam logic [SLOT_W-1:0] SLOT_CNT_RST = 4'd10;

  // event kinds
  localparam logic [1:0] EV_CONTACT = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_SYNC    = 2'd2;

  // record phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic accept;        // take the input transaction
    logic walk_step;     // examine slot at scan pointer, release if active
    logic load_contact;  // emit contact for the decoded record
    logic load_sync;     // emit sync and close the report
  } trsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rec_complete;   // accepted byte completes a record
    logic in_end;         // accepted byte closes the report
    logic end_pending;    // held report-end flag
    logic rec_walk_done;  // scan pointer reached the record's slot
    logic end_walk_done;  // scan pointer reached the slot limit
    logic cur_active;     // slot under the scan pointer is active
    logic out_free;       // output register can take an event
  } trsd_sts_t;

endpackage

>>> rtl/touch_report_slot_decoder_core.sv
// ----------------------------------------------------------------------------
// Touch report slot decoder core
// Turns a byte stream of touch reports into contact, release and sync events.
// ----------------------------------------------------------------------------
// Input stream: one report byte per transaction, in_tlast on the final byte.
// Output stream: one event per transaction; tuser carries the event kind,
// tlast marks the sync that closes a report. Registers sit on the APB port:
// slot_count at byte address 0 (values above 10 act as 10).
// Sequence: a header or record byte that emits nothing is taken in the idle
// state. A byte that completes a record starts a release scan up to the
// record's slot, then loads the contact; the final byte adds a scan from the
// scan pointer up to the slot limit, then loads the sync. The scan pointer
// steps one slot per cycle while the receiver does not stall.
// Events leave through a single output register: a byte that emits nothing
// is accepted while an event waits, and a stalled receiver holds the scan
// at the next event. Reset clears all active flags, the header state and the
// output valid flag, and sets slot_count to 10.
// ----------------------------------------------------------------------------
`include "touch_report_slot_decoder_core_assert.svh"

module touch_report_slot_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: report_byte[7:0]
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: slot[3:0], x_pos[15:4], y_pos[27:16], truncated[28], zero[31:29]
  output logic [31:0] out_tdata,
  // tuser: event_kind[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import trsd_pkg::*;

  localparam logic REG_SLOT_COUNT = 1'b0;

  logic [SLOT_W-1:0] slot_count_r, slot_count_nxt;
  logic [SLOT_W-1:0] slot_lim;
  logic              cfg_wr;
  trsd_cmd_t         cmd;
  trsd_sts_t         sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    slot_count_nxt = slot_count_r;
    if (cfg_wr && (cfg_paddr[2] == REG_SLOT_COUNT)) slot_count_nxt = cfg_pwdata[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_CNT_RST;
    end else begin
      slot_count_r <= slot_count_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SLOT_COUNT) ? {28'h0, slot_count_r} : 32'h0;
  assign slot_lim   = (slot_count_r > SLOT_W'(NUM_SLOTS)) ? SLOT_W'(NUM_SLOTS)
                                                          : slot_count_r;

  trsd_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  trsd_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .slot_lim   (slot_lim),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `TRSD_ASSERT_IMP(a_load_needs_room, clk, rst_n, (cmd.load_contact || cmd.load_sync || (cmd.walk_step && sts.cur_active)), sts.out_free, "event loaded into a busy output register")
  `TRSD_ASSERT_IMP(a_single_load, clk, rst_n, 1'b1, $onehot0({cmd.load_contact, cmd.load_sync, (cmd.walk_step && sts.cur_active)}), "two events loaded in one cycle")
  `TRSD_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_tready, !(cmd.walk_step || cmd.load_contact || cmd.load_sync), "input ready while the scan is busy")
  `TRSD_ASSERT_NEXT(a_sync_last, clk, rst_n, cmd.load_sync, (out_tvalid && out_tlast && (out_tuser == EV_SYNC)), "sync not presented with tlast")

endmodule

>>> rtl/trsd_datapath.sv
// ----------------------------------------------------------------------------
// Touch report slot decoder datapath
// Header mask, record assembly, slot flags, scan pointer and output register.
// ----------------------------------------------------------------------------
module trsd_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic [trsd_pkg::SLOT_W-1:0]      slot_lim,
  input  trsd_pkg::trsd_cmd_t              cmd,
  output trsd_pkg::trsd_sts_t              sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [trsd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import trsd_pkg::*;

  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [NUM_SLOTS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [SLOT_W-1:0]    scan_r, scan_nxt;
  logic                 short_r, short_nxt;
  logic                 end_r, end_nxt;
  logic [SLOT_W-1:0]    tgt_r, tgt_nxt;
  logic [15:0]          held_r, held_nxt;
  logic [7:0]           ylo_r, ylo_nxt;

  logic                  ov_r, ov_nxt;
  logic [1:0]            okind_r, okind_nxt;
  logic [SLOT_W-1:0]     oslot_r, oslot_nxt;
  logic [COORD_W-1:0]    ox_r, ox_nxt;
  logic [COORD_W-1:0]    oy_r, oy_nxt;
  logic                  otr_r, otr_nxt;
  logic                  olast_r, olast_nxt;

  logic [NUM_SLOTS-1:0] elig;
  logic                 found;
  logic [SLOT_W-1:0]    tgt;
  logic                 out_free;
  logic                 release_now;

  // first touched slot at or above the scan pointer and below the limit
  always_comb begin
    found = 1'b0;
    tgt   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      elig[i] = mask_r[i] && (SLOT_W'(i) >= scan_r) && (SLOT_W'(i) < slot_lim);
      if (elig[i] && !found) begin
        found = 1'b1;
        tgt   = SLOT_W'(i);
      end
    end
  end

  assign out_free    = !ov_r || out_tready;
  assign release_now = cmd.walk_step && active_r[scan_r];

  always_comb begin
    sts.rec_complete  = (cnt_r > 6'd1) && found && (phase_r == PH_THIRD);
    sts.in_end        = in_last;
    sts.end_pending   = end_r;
    sts.rec_walk_done = scan_r >= tgt_r;
    sts.end_walk_done = scan_r >= slot_lim;
    sts.cur_active    = active_r[scan_r];
    sts.out_free      = out_free;
  end

  always_comb begin
    active_nxt = active_r;
    mask_nxt   = mask_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    scan_nxt   = scan_r;
    short_nxt  = short_r;
    end_nxt    = end_r;
    tgt_nxt    = tgt_r;
    held_nxt   = held_r;
    ylo_nxt    = ylo_r;

    ov_nxt    = ov_r && !out_tready;
    okind_nxt = okind_r;
    oslot_nxt = oslot_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    otr_nxt   = otr_r;
    olast_nxt = olast_r;

    if (cmd.accept) begin
      if (cnt_r == 6'd0) begin
        mask_nxt  = {2'b00, in_byte};
        scan_nxt  = '0;
        phase_nxt = PH_FIRST;
        short_nxt = 1'b0;
      end else if (cnt_r == 6'd1) begin
        mask_nxt = mask_r | {in_byte[5:4], 8'h00};
      end else if (found) begin
        case (phase_r)
          PH_FIRST: begin
            held_nxt[15:8] = in_byte;
            phase_nxt      = PH_SECOND;
          end
          PH_SECOND: begin
            held_nxt[7:0] = in_byte;
            phase_nxt     = PH_THIRD;
          end
          default: begin
            ylo_nxt   = in_byte;
            tgt_nxt   = tgt;
            phase_nxt = PH_FIRST;
          end
        endcase
      end
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + 6'd1;
      end_nxt = in_last;
      // a short report counts as an empty mask
      if (in_last && (cnt_r <= 6'd1)) mask_nxt = '0;
    end

    if (cmd.walk_step) begin
      if (mask_r[scan_r]) short_nxt = 1'b1;
      if (release_now) begin
        active_nxt[scan_r] = 1'b0;
        ov_nxt    = 1'b1;
        okind_nxt = EV_RELEASE;
        oslot_nxt = scan_r;
        ox_nxt    = '0;
        oy_nxt    = '0;
        otr_nxt   = 1'b0;
        olast_nxt = 1'b0;
      end
      scan_nxt = scan_r + 4'd1;
    end

    if (cmd.load_contact) begin
      active_nxt[tgt_r] = 1'b1;
      scan_nxt  = tgt_r + 4'd1;
      ov_nxt    = 1'b1;
      okind_nxt = EV_CONTACT;
      oslot_nxt = tgt_r;
      ox_nxt    = {held_r[15:12], held_r[7:0]};
      oy_nxt    = {held_r[11:8], ylo_r};
      otr_nxt   = 1'b0;
      olast_nxt = 1'b0;
    end

    if (cmd.load_sync) begin
      ov_nxt    = 1'b1;
      okind_nxt = EV_SYNC;
      oslot_nxt = '0;
      ox_nxt    = '0;
      oy_nxt    = '0;
      otr_nxt   = short_r;
      olast_nxt = 1'b1;
      cnt_nxt   = '0;
      mask_nxt  = '0;
      scan_nxt  = '0;
      phase_nxt = PH_FIRST;
      short_nxt = 1'b0;
      end_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      mask_r   <= '0;
      cnt_r    <= '0;
      phase_r  <= PH_FIRST;
      scan_r   <= '0;
      short_r  <= 1'b0;
      end_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      active_r <= active_nxt;
      mask_r   <= mask_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      scan_r   <= scan_nxt;
      short_r  <= short_nxt;
      end_r    <= end_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    held_r  <= held_nxt;
    ylo_r   <= ylo_nxt;
    okind_r <= okind_nxt;
    oslot_r <= oslot_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    otr_r   <= otr_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'b000, otr_r, oy_r, ox_r, oslot_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

>>> rtl/trsd_controller.sv
// ----------------------------------------------------------------------------
// Touch report slot decoder controller
// Sequences byte intake, release scans, contact and sync emission.
// ----------------------------------------------------------------------------
module trsd_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  trsd_pkg::trsd_sts_t  sts,
  output trsd_pkg::trsd_cmd_t  cmd
);
  import trsd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_REC_WALK = 5'b00010,
    S_CONTACT  = 5'b00100,
    S_END_WALK = 5'b01000,
    S_SYNC     = 5'b10000
  } trsd_state_t;

  trsd_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          if (sts.rec_complete)  state_nxt = S_REC_WALK;
          else if (sts.in_end)   state_nxt = S_END_WALK;
        end
      end
      S_REC_WALK: begin
        // release skipped active slots below the record's slot
        if (sts.rec_walk_done) state_nxt = S_CONTACT;
        else cmd.walk_step = !sts.cur_active || sts.out_free;
      end
      S_CONTACT: begin
        if (sts.out_free) begin
          cmd.load_contact = 1'b1;
          state_nxt = sts.end_pending ? S_END_WALK : S_IDLE;
        end
      end
      S_END_WALK: begin
        if (sts.end_walk_done) state_nxt = S_SYNC;
        else cmd.walk_step = !sts.cur_active || sts.out_free;
      end
      S_SYNC: begin
        if (sts.out_free) begin
          cmd.load_sync = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
